// ----- rtl/bbmdc_pkg.sv -----
// Shared types, constants and register codes for the buck-boost mode and duty control block.
// Used by every module under rtl; depends on nothing else.
package bbmdc_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned IDX_W  = 3;

  localparam logic [1:0] MODE_SHUTDOWN  = 2'd0;
  localparam logic [1:0] MODE_BUCK      = 2'd1;
  localparam logic [1:0] MODE_BOOST     = 2'd2;
  localparam logic [1:0] MODE_BUCKBOOST = 2'd3;

  localparam logic [IDX_W-1:0] REG_TARGET     = 3'd0;
  localparam logic [IDX_W-1:0] REG_BAND       = 3'd1;
  localparam logic [IDX_W-1:0] REG_OVERVOLT   = 3'd2;
  localparam logic [IDX_W-1:0] REG_BUCK_LOW   = 3'd3;
  localparam logic [IDX_W-1:0] REG_BUCK_HIGH  = 3'd4;
  localparam logic [IDX_W-1:0] REG_BOOST_LOW  = 3'd5;
  localparam logic [IDX_W-1:0] REG_BOOST_HIGH = 3'd6;

  localparam logic [DATA_W-1:0] PWM_PERIOD_COUNT  = 16'd32768;
  localparam logic [DATA_W-1:0] BOOST_BUCK_CMP    = PWM_PERIOD_COUNT + 16'd1;
  localparam logic [DATA_W-1:0] BB_LOW_LIMIT      = 16'd1024;
  localparam logic [DATA_W-1:0] BB_HIGH_LIMIT     = 16'd30000;
  localparam logic [DATA_W-1:0] CURRENT_THRESHOLD = 16'd60;

  // floor(x / 100) == (x * 83887) >> 23 for every 16-bit x.
  localparam logic [16:0] STEP_RECIP = 17'd83887;
  localparam int unsigned STEP_SHIFT = 23;
  localparam int unsigned STEP_W     = 10;

  typedef struct packed {
    logic [DATA_W-1:0] target_output;
    logic [DATA_W-1:0] mode_band;
    logic [DATA_W-1:0] overvoltage_level;
    logic [DATA_W-1:0] buck_low_limit;
    logic [DATA_W-1:0] buck_high_limit;
    logic [DATA_W-1:0] boost_low_limit;
    logic [DATA_W-1:0] boost_high_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       overvolt;
  } mode_dec_t;

  typedef struct packed {
    logic [DATA_W-1:0] duty;
    logic [DATA_W-1:0] buck_cmp;
    logic [DATA_W-1:0] boost_cmp;
    logic [DATA_W-1:0] trig_cmp;
  } duty_res_t;

endpackage

// ----- rtl/bbmdc_cfg.sv -----
// Configuration register file for the buck-boost mode and duty control block.
// Depends on bbmdc_pkg.
module bbmdc_cfg (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  wr_en,
  input  logic [bbmdc_pkg::IDX_W-1:0]           wr_index,
  input  logic [bbmdc_pkg::DATA_W-1:0]          wr_data,
  output bbmdc_pkg::cfg_t                       cfg
);
  import bbmdc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_TARGET:     cfg_nxt.target_output     = wr_data;
        REG_BAND:       cfg_nxt.mode_band         = wr_data;
        REG_OVERVOLT:   cfg_nxt.overvoltage_level = wr_data;
        REG_BUCK_LOW:   cfg_nxt.buck_low_limit    = wr_data;
        REG_BUCK_HIGH:  cfg_nxt.buck_high_limit   = wr_data;
        REG_BOOST_LOW:  cfg_nxt.boost_low_limit   = wr_data;
        REG_BOOST_HIGH: cfg_nxt.boost_high_limit  = wr_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{default: '0, overvoltage_level: '1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/bbmdc_mode.sv -----
// Mode decision: buck, boost or buck-boost from the averaged input against the target,
// with overvoltage shutdown. Depends on bbmdc_pkg.
module bbmdc_mode (
  input  logic [bbmdc_pkg::DATA_W-1:0] input_volts,
  input  logic [bbmdc_pkg::DATA_W-1:0] output_volts,
  input  logic [bbmdc_pkg::DATA_W-1:0] input_volts_avg,
  input  bbmdc_pkg::cfg_t              cfg,
  input  logic [1:0]                   mode_prev,
  output bbmdc_pkg::mode_dec_t         dec
);
  import bbmdc_pkg::*;

  logic [DATA_W:0]   avg_plus_band;
  logic [DATA_W:0]   tgt_plus_band;
  logic [DATA_W-1:0] abs_diff;
  logic [1:0]        band_mode;
  logic              overvolt;

  always_comb begin
    avg_plus_band = {1'b0, input_volts_avg} + {1'b0, cfg.mode_band};
    tgt_plus_band = {1'b0, cfg.target_output} + {1'b0, cfg.mode_band};
    abs_diff = (input_volts_avg >= cfg.target_output) ?
               (input_volts_avg - cfg.target_output) :
               (cfg.target_output - input_volts_avg);

    // Target below avg - band is tested as target + band < avg to stay unsigned.
    if ({1'b0, cfg.target_output} > avg_plus_band) begin
      band_mode = MODE_BOOST;
    end else if (tgt_plus_band < {1'b0, input_volts_avg}) begin
      band_mode = MODE_BUCK;
    end else if (abs_diff < cfg.mode_band) begin
      band_mode = MODE_BUCKBOOST;
    end else begin
      band_mode = mode_prev;
    end

    overvolt = (input_volts >= cfg.overvoltage_level) ||
               (output_volts >= cfg.overvoltage_level);

    dec.overvolt = overvolt;
    dec.mode     = overvolt ? MODE_SHUTDOWN : band_mode;
  end

endmodule

// ----- rtl/bbmdc_duty.sv -----
// Duty step, mode-dependent clamp and compare value generation.
// Depends on bbmdc_pkg.
module bbmdc_duty (
  input  logic [bbmdc_pkg::DATA_W-1:0] output_volts,
  input  logic [bbmdc_pkg::DATA_W-1:0] input_current_avg,
  input  bbmdc_pkg::cfg_t              cfg,
  input  bbmdc_pkg::mode_dec_t         dec,
  input  bbmdc_pkg::duty_res_t         prev,
  output bbmdc_pkg::duty_res_t         res
);
  import bbmdc_pkg::*;

  function automatic logic [DATA_W-1:0] clamp16(input logic [DATA_W:0]   x,
                                               input logic [DATA_W-1:0] hi,
                                               input logic [DATA_W-1:0] lo);
    logic [DATA_W-1:0] r;
    if (x > {1'b0, lo}) begin
      r = (x < {1'b0, hi}) ? x[DATA_W-1:0] : hi;
    end else begin
      r = lo;
    end
    return r;
  endfunction

  logic                     v_lt;
  logic                     v_gt;
  logic [DATA_W-1:0]        diff;
  logic [DATA_W+16:0]       prod;
  logic [STEP_W-1:0]        step;
  logic                     do_add;
  logic                     do_sub;
  logic [DATA_W:0]          sum;
  logic [DATA_W:0]          dc;
  logic [DATA_W-1:0]        hi;
  logic [DATA_W-1:0]        lo;
  logic [DATA_W-1:0]        dc_clamped;
  logic [DATA_W-1:0]        trig;

  always_comb begin
    v_lt = output_volts < cfg.target_output;
    v_gt = output_volts > cfg.target_output;
    diff = v_lt ? (cfg.target_output - output_volts) : (output_volts - cfg.target_output);
    prod = diff * STEP_RECIP;
    step = prod[STEP_SHIFT +: STEP_W];

    // At the current threshold with output above target both moves apply and cancel.
    do_add = v_lt || (input_current_avg <= CURRENT_THRESHOLD);
    do_sub = v_gt && (input_current_avg >= CURRENT_THRESHOLD);

    sum = {1'b0, prev.duty} + (do_add ? {{(DATA_W+1-STEP_W){1'b0}}, step} : '0);
    if (do_sub) begin
      dc = (sum < {{(DATA_W+1-STEP_W){1'b0}}, step}) ? '0 :
           (sum - {{(DATA_W+1-STEP_W){1'b0}}, step});
    end else begin
      dc = sum;
    end

    case (dec.mode)
      MODE_BUCK: begin
        hi = cfg.buck_high_limit;
        lo = cfg.buck_low_limit;
      end
      MODE_BOOST: begin
        hi = cfg.boost_high_limit;
        lo = cfg.boost_low_limit;
      end
      default: begin
        hi = BB_HIGH_LIMIT;
        lo = BB_LOW_LIMIT;
      end
    endcase

    dc_clamped = clamp16(dc, hi, lo);
    trig = clamp16({1'b0, dc[DATA_W:1]}, {1'b0, hi[DATA_W-1:1]}, {1'b0, lo[DATA_W-1:1]});

    res = prev;
    case (dec.mode)
      MODE_SHUTDOWN: begin
        res.duty = dec.overvolt ? '0 : prev.duty;
      end
      MODE_BUCK: begin
        res.duty      = dc_clamped;
        res.buck_cmp  = dc_clamped;
        res.boost_cmp = '0;
        res.trig_cmp  = trig;
      end
      MODE_BOOST: begin
        res.duty      = dc_clamped;
        res.buck_cmp  = BOOST_BUCK_CMP;
        res.boost_cmp = dc_clamped;
        res.trig_cmp  = trig;
      end
      default: begin
        res.duty      = dc_clamped;
        res.buck_cmp  = dc_clamped;
        res.boost_cmp = dc_clamped;
        res.trig_cmp  = trig;
      end
    endcase
  end

endmodule

// ----- rtl/buck_boost_mode_and_duty_control_top.sv -----
// Top level of the buck-boost mode and duty control block: input register, decision and
// duty logic, state and output register. Depends on bbmdc_pkg, bbmdc_cfg, bbmdc_mode, bbmdc_duty.
//
// One item per PWM period tick goes in; exactly one result comes out, through the input register and
// then the output register, once the output side is ready. A new item can be taken every cycle while
// the output side is ready: the duty, mode and held compare state is updated in the same cycle that an item
// moves from the input register to the output register, so that feedback loop sets the rate. The output
// register decouples the two sides, so an item is accepted while a result still waits.
// Configuration writes are always taken (cfg_ready is high) and must only happen while idle.
module buck_boost_mode_and_duty_control_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: input_volts[15:0], output_volts[31:16], input_volts_avg[47:32],
  //           input_current_avg[63:48]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [63:0]                      in_tdata,
  // out_tdata: mode[1:0], drive_enable[2], buck_compare[18:3], boost_compare[34:19],
  //            adc_trigger_compare[50:35], zero[55:51]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [55:0]                      out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bbmdc_pkg::IDX_W-1:0]      cfg_index,
  input  logic [bbmdc_pkg::DATA_W-1:0]     cfg_data
);
  import bbmdc_pkg::*;

  cfg_t      cfg;
  mode_dec_t dec;
  duty_res_t state_r;
  duty_res_t state_nxt;

  logic        s1_valid_r;
  logic [63:0] s1_data_r;
  logic [1:0]  mode_r;
  logic        out_valid_r;
  logic [55:0] out_data_r;
  logic        advance;
  logic        in_fire;

  assign cfg_ready = 1'b1;

  bbmdc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bbmdc_mode u_mode (
    .input_volts     (s1_data_r[15:0]),
    .output_volts    (s1_data_r[31:16]),
    .input_volts_avg (s1_data_r[47:32]),
    .cfg             (cfg),
    .mode_prev       (mode_r),
    .dec             (dec)
  );

  bbmdc_duty u_duty (
    .output_volts      (s1_data_r[31:16]),
    .input_current_avg (s1_data_r[63:48]),
    .cfg               (cfg),
    .dec               (dec),
    .prev              (state_r),
    .res               (state_nxt)
  );

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_SHUTDOWN;
      state_r     <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        mode_r      <= dec.mode;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_tdata;
    end
    if (advance) begin
      out_data_r <= {5'b0, state_nxt.trig_cmp, state_nxt.boost_cmp, state_nxt.buck_cmp,
                     (dec.mode != MODE_SHUTDOWN), dec.mode};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // The drive enable bit of a shown result matches its mode field.
  a_enable_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[2] == (out_data_r[1:0] != MODE_SHUTDOWN)))
    else $error("drive_enable disagrees with mode");

  // An overvoltage item clears the duty state.
  a_overvolt_clears_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && dec.overvolt) |=> (state_r.duty == '0) && (mode_r == MODE_SHUTDOWN))
    else $error("overvoltage did not clear duty");

  // While in boost mode the buck side is held fully on.
  a_boost_holds_buck: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_BOOST) |-> (state_r.buck_cmp == BOOST_BUCK_CMP))
    else $error("boost mode without buck side held on");

  // A buffered item waiting for the output register is never dropped.
  a_s1_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> s1_valid_r)
    else $error("input register lost an item");

  // Shutdown leaves the held compare values unchanged.
  a_shutdown_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && dec.mode == MODE_SHUTDOWN) |=> $stable(state_r.buck_cmp) &&
      $stable(state_r.boost_cmp) && $stable(state_r.trig_cmp))
    else $error("shutdown changed held compares");
`endif

endmodule
